[sv/velocity_key_matrix_scanner_top_assert.svh]
// Assertion macros for the velocity key matrix scanner.
`ifndef VELOCITY_KEY_MATRIX_SCANNER_TOP_ASSERT_SVH
`define VELOCITY_KEY_MATRIX_SCANNER_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define VKMS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("velocity key matrix scanner check failed");
// Checked at every edge, reset included.
`define VKMS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("velocity key matrix scanner check failed");
`else
`define VKMS_ASSERT(label, clk, rst_n, prop)
`define VKMS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/vkms_pkg.sv]
// Package with types, constants and helper functions of the velocity key matrix scanner.
`default_nettype none
package vkms_pkg;

	localparam int NUM_BANKS_DEFAULT = 8;
	localparam int BANK_KEYS = 8;

	localparam logic [7:0]  PIN_MASK_RESET = 8'hFF;
	localparam logic [15:0] ELAPSED_SAT    = 16'd255;
	localparam logic [6:0]  VEL_SAT        = 7'd127;

	// Contact row that a bank read reports.
	typedef enum logic {
		OP_START = 1'b0,
		OP_FULL  = 1'b1
	} op_t;

	typedef logic [BANK_KEYS-1:0][15:0] stamp_row_t;
	typedef logic [BANK_KEYS-1:0][6:0]  vel_row_t;

	// Press time in 2 ms steps, pinned at the top once 255 ms have gone by.
	function automatic logic [6:0] calc_velocity(input logic [15:0] now_v,
			input logic [15:0] stamp_v);
		logic [15:0] elapsed;
		elapsed = now_v - stamp_v;
		if (elapsed >= ELAPSED_SAT) begin
			return VEL_SAT;
		end
		return elapsed[7:1];
	endfunction

	// Position of the lowest set bit; zero for an empty mask.
	function automatic logic [2:0] lowest_idx(input logic [BANK_KEYS-1:0] m);
		logic [2:0] idx;
		idx = '0;
		for (int i = BANK_KEYS - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[sv/velocity_key_matrix_scanner_top.sv]
// An item waits in the input register until the event register is free, which then shows
// its events. One item per cycle when each yields at most one event and out_ready is high;
// an item with more events waits in the input stage while they drain one event per cycle.
// Reset (arst_n low, asynchronous) clears contact history, key-down bits, press stamps,
// all valid flags and sets pin_mask to 255; no clearing pass follows reset.
`default_nettype none
`include "velocity_key_matrix_scanner_top_assert.svh"
module velocity_key_matrix_scanner_top #(
	parameter int NUM_BANKS = vkms_pkg::NUM_BANKS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  pin_mask,
	// Bank read items.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [2:0]  bank,
	input  wire logic [7:0]  pin_levels,
	input  wire logic [15:0] now,
	// Key events.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       key,
	output logic             is_on,
	output logic [6:0]       velocity,
	output logic             last
);
	import vkms_pkg::*;

	// Row index into the per-bank state; only its low bits are needed.
	localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	// The configuration register. The user must write it only while the block is idle; the
	// block itself does not enforce this, and the channel is always ready.
	logic [7:0] pin_mask_q;

	// Input stage: the accepted bank read waits here until the event register is free.
	logic        s1_valid_q;
	op_t         op_s1;
	logic [2:0]  bank_s1;
	logic [7:0]  pin_levels_s1;
	logic [15:0] now_s1;

	// Per-bank key state, one row per bank of eight keys.
	logic [BANK_KEYS-1:0] start_prev_q [NUM_BANKS];
	logic [BANK_KEYS-1:0] full_prev_q  [NUM_BANKS];
	logic [BANK_KEYS-1:0] key_down_q   [NUM_BANKS];
	stamp_row_t           stamp_q      [NUM_BANKS];

	// Event register: a mask of pending events for one bank, drained lowest bit first.
	logic [BANK_KEYS-1:0] ev_mask_q;
	logic [2:0]           ev_bank_q;
	logic                 ev_on_q;
	vel_row_t             ev_vel_q;

	logic [BANK_IDX_W-1:0] row;
	logic                  bank_ok;
	logic [BANK_KEYS-1:0]  sw;
	logic [BANK_KEYS-1:0]  prev;
	logic [BANK_KEYS-1:0]  changes;
	logic [BANK_KEYS-1:0]  rising;
	logic [BANK_KEYS-1:0]  falling;
	logic [BANK_KEYS-1:0]  down;
	logic [BANK_KEYS-1:0]  down_next;
	logic [BANK_KEYS-1:0]  ev_mask;
	vel_row_t              vel_next;
	logic                  upd;
	logic                  out_fire;
	logic                  drain_free;
	logic                  s1_advance;
	logic [2:0]            ev_idx;
	logic [BANK_KEYS-1:0]  ev_rest;

	assign cfg_ready = 1'b1;

	// The event register is free when it is empty, or when its final event leaves now.
	assign out_valid  = (ev_mask_q != '0);
	assign out_fire   = out_valid && out_ready;
	assign ev_rest    = ev_mask_q & (ev_mask_q - BANK_KEYS'(1));
	assign drain_free = !out_valid || (out_ready && (ev_rest == '0));
	assign s1_advance = s1_valid_q && drain_free;
	assign in_ready   = !s1_valid_q || drain_free;

	// The output shows the lowest pending event of the bank in the event register.
	assign ev_idx   = lowest_idx(ev_mask_q);
	assign key      = {ev_bank_q, ev_idx};
	assign is_on    = ev_on_q;
	assign velocity = ev_vel_q[ev_idx];
	assign last     = (ev_rest == '0);

	// Bank reads beyond the configured number of banks are dropped without effect.
	assign row     = bank_s1[BANK_IDX_W-1:0];
	assign bank_ok = ({1'b0, bank_s1} < 4'(NUM_BANKS));

	always_comb begin
		sw      = ~pin_levels_s1 & pin_mask_q;
		prev    = (op_s1 == OP_FULL) ? full_prev_q[row] : start_prev_q[row];
		changes = sw ^ prev;
		rising  = changes & sw;
		falling = changes & prev;
		down    = key_down_q[row];
		for (int i = 0; i < BANK_KEYS; i++) begin
			vel_next[i] = '0;
		end
		unique case (op_s1)
			OP_START: begin
				// A start contact that opens on a key that is down ends the note.
				ev_mask   = falling & down;
				down_next = down & ~ev_mask;
			end
			OP_FULL: begin
				// A full-down contact that closes on a released key starts the note.
				ev_mask   = rising & ~down;
				down_next = down | ev_mask;
				for (int i = 0; i < BANK_KEYS; i++) begin
					vel_next[i] = calc_velocity(now_s1, stamp_q[row][i]);
				end
			end
			default: begin
				ev_mask   = '0;
				down_next = down;
			end
		endcase
		upd = s1_advance && bank_ok && (changes != '0);
		if (!upd) begin
			ev_mask = '0;
		end
	end

	// Control and key state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_mask_q <= PIN_MASK_RESET;
			s1_valid_q <= 1'b0;
			ev_mask_q  <= '0;
			for (int b = 0; b < NUM_BANKS; b++) begin
				start_prev_q[b] <= '0;
				full_prev_q[b]  <= '0;
				key_down_q[b]   <= '0;
				stamp_q[b]      <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				pin_mask_q <= pin_mask;
			end
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_advance) begin
				ev_mask_q <= ev_mask;
			end else if (out_fire) begin
				ev_mask_q <= ev_rest;
			end
			if (upd) begin
				key_down_q[row] <= down_next;
				if (op_s1 == OP_START) begin
					start_prev_q[row] <= sw;
					for (int i = 0; i < BANK_KEYS; i++) begin
						if (rising[i]) begin
							stamp_q[row][i] <= now_s1;
						end
					end
				end else begin
					full_prev_q[row] <= sw;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1         <= op_t'(op);
			bank_s1       <= bank;
			pin_levels_s1 <= pin_levels;
			now_s1        <= now;
		end
		if (s1_advance) begin
			ev_bank_q <= bank_s1;
			ev_on_q   <= (op_s1 == OP_FULL);
			ev_vel_q  <= vel_next;
		end
	end

	// A bank's events keep coming until the one marked last has been taken.
	`VKMS_ASSERT(a_drain_continues, clk, arst_n, out_fire && !last |=> out_valid)
	// With nothing new loaded, taking the last event leaves the output empty.
	`VKMS_ASSERT(a_drain_ends, clk, arst_n, out_fire && last && !s1_advance |=> !out_valid)
	// Events only name keys of configured banks.
	`VKMS_ASSERT(a_key_bank, clk, arst_n, out_valid |-> ({1'b0, key[5:3]} < 4'(NUM_BANKS)))
	// Key-off events carry no velocity.
	`VKMS_ASSERT(a_off_vel, clk, arst_n, out_valid && !is_on |-> velocity == 7'd0)
	// Nothing is shown while reset is held.
	`VKMS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid)

endmodule
`default_nettype wire

[test/tb_velocity_key_matrix_scanner_top.sv]
// Testbench for the velocity key matrix scanner, checking key events against a predictor.
module tb_velocity_key_matrix_scanner_top;
	import vkms_pkg::*;

	localparam int BANKS = vkms_pkg::NUM_BANKS_DEFAULT;
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// An item with no events may still sit in the input register when the
	// last expected event has gone out; this covers it before a mask write.
	localparam int SETTLE_CYCLES = 12;

	// One bank read as it goes onto the input channel.
	typedef struct packed {
		op_t         op;
		logic [2:0]  bank;
		logic [7:0]  levels;
		logic [15:0] at_ms;
	} bank_read_t;

	// One key event as the block should send it.
	typedef struct packed {
		logic [5:0] key;
		logic       is_on;
		logic [6:0] velocity;
		logic       last;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  pin_mask = 8'hFF;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [2:0]  bank = 3'd0;
	logic [7:0]  pin_levels = 8'hFF;
	logic [15:0] now = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  key;
	logic        is_on;
	logic [6:0]  velocity;
	logic        last;

	velocity_key_matrix_scanner_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.pin_mask   (pin_mask),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.bank       (bank),
		.pin_levels (pin_levels),
		.now        (now),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key        (key),
		.is_on      (is_on),
		.velocity   (velocity),
		.last       (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Items waiting for the driver, and events waiting for the monitor.
	bank_read_t bank_reads[$];
	key_event_t key_events[$];

	// Predictor state: what the scanner should remember about every bank.
	logic [7:0]  mask_now = 8'hFF;
	logic [7:0]  start_seen [BANKS];
	logic [7:0]  full_seen [BANKS];
	logic [7:0]  held_down [BANKS];
	logic [15:0] press_ms [BANKS*8];

	// Stimulus-side picture of the physical contacts, used to shape key motions.
	logic [7:0]  start_closed [8];
	logic [7:0]  full_closed [8];
	logic [15:0] ms;

	int reads_queued = 0;
	int reads_taken = 0;
	int events_checked = 0;
	int ons_seen = 0;
	int offs_seen = 0;
	int mismatches = 0;
	int mask_writes = 0;
	int in_gap = 0;
	int in_calm = 0;
	int out_stall = 0;
	int out_calm = 0;
	int idle_cycles = 0;

	initial begin
		for (int b = 0; b < BANKS; b++) begin
			start_seen[b] = 8'h00;
			full_seen[b] = 8'h00;
			held_down[b] = 8'h00;
		end
		for (int k = 0; k < BANKS * 8; k++) begin
			press_ms[k] = 16'h0000;
		end
		for (int b = 0; b < 8; b++) begin
			start_closed[b] = 8'h00;
			full_closed[b] = 8'h00;
		end
	end

	// Works out the events that one accepted bank read causes and queues them.
	function automatic void predict_bank_read(bank_read_t r);
		logic [7:0]  sw;
		logic [7:0]  prev;
		logic [7:0]  changes;
		logic [7:0]  rising;
		logic [7:0]  falling;
		logic [7:0]  down;
		logic [15:0] elapsed;
		logic [5:0]  k;
		key_event_t  evs[8];
		int          n;
		n = 0;
		if (int'(r.bank) >= BANKS) begin
			return;
		end
		// Pins are active low; the mask drops lines that are not keys.
		sw = ~r.levels & mask_now;
		prev = (r.op == OP_START) ? start_seen[r.bank] : full_seen[r.bank];
		changes = sw ^ prev;
		if (changes == 8'h00) begin
			return;
		end
		rising = changes & sw;
		falling = changes & prev;
		down = held_down[r.bank];
		if (r.op == OP_START) begin
			start_seen[r.bank] = sw;
			for (int i = 0; i < 8; i++) begin
				k = {r.bank, 3'(i)};
				if (rising[i]) begin
					press_ms[k] = r.at_ms;
				end
				if (falling[i] && down[i]) begin
					evs[n] = '{key: k, is_on: 1'b0, velocity: 7'd0, last: 1'b0};
					n++;
					down[i] = 1'b0;
				end
			end
		end else begin
			full_seen[r.bank] = sw;
			for (int i = 0; i < 8; i++) begin
				k = {r.bank, 3'(i)};
				if (rising[i] && !down[i]) begin
					// The timer wraps, so the difference is taken in 16 bits.
					elapsed = r.at_ms - press_ms[k];
					evs[n].key = k;
					evs[n].is_on = 1'b1;
					evs[n].velocity = (elapsed >= 16'd255) ? 7'd127 : elapsed[7:1];
					evs[n].last = 1'b0;
					n++;
					down[i] = 1'b1;
				end
			end
		end
		held_down[r.bank] = down;
		for (int j = 0; j < n; j++) begin
			evs[j].last = (j == n - 1);
			key_events.push_back(evs[j]);
		end
	endfunction

	// Compares the event on the output with the oldest one expected.
	function automatic void check_key_event();
		key_event_t want;
		events_checked++;
		if (key_events.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Unexpected key event: key %0d on %0b velocity %0d last %0b",
					key, is_on, velocity, last);
			end
			return;
		end
		want = key_events.pop_front();
		if (key !== want.key || is_on !== want.is_on || velocity !== want.velocity ||
				last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Key event %0d wrong: expected key %0d on %0b velocity %0d last %0b",
					events_checked, want.key, want.is_on, want.velocity, want.last);
				$display("    got key %0d on %0b velocity %0d last %0b",
					key, is_on, velocity, last);
			end
		end else if (want.is_on) begin
			ons_seen++;
		end else begin
			offs_seen++;
		end
	endfunction

	// Idle length before the next item or stall length on the output side.
	// Mostly zero or short, sometimes long, and now and then a calm stretch.
	function automatic int draw_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic void queue_read(op_t o, logic [2:0] b, logic [7:0] lv, logic [15:0] t);
		bank_read_t r;
		r.op = o;
		r.bank = b;
		r.levels = lv;
		r.at_ms = t;
		bank_reads.push_back(r);
		reads_queued++;
	endfunction

	// A physically plausible key motion: the start contact moves only while the
	// full-down contact is open, and the full-down contact only on pressed starts.
	function automatic void queue_key_motion();
		logic [2:0] b;
		logic [7:0] flip;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			ms += 16'($urandom_range(0, 12));
		end else if (r < 95) begin
			ms += 16'($urandom_range(13, 150));
		end else begin
			ms += 16'($urandom_range(200, 700));
		end
		b = 3'($urandom_range(0, 7));
		// Usually one or two keys move, now and then a whole chord.
		flip = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom & $urandom & $urandom);
		if ($urandom_range(0, 1) == 0) begin
			flip &= ~full_closed[b];
			start_closed[b] ^= flip;
			queue_read(OP_START, b, ~start_closed[b], ms);
		end else begin
			flip &= start_closed[b];
			full_closed[b] ^= flip;
			queue_read(OP_FULL, b, ~full_closed[b], ms);
		end
	endfunction

	// Bounce or a bad read: any levels on any row, with an arbitrary timer.
	function automatic void queue_noise();
		op_t        o;
		logic [2:0] b;
		logic [7:0] lv;
		o = op_t'($urandom_range(0, 1));
		b = 3'($urandom_range(0, 7));
		lv = 8'($urandom);
		if (o == OP_START) begin
			start_closed[b] = ~lv;
		end else begin
			full_closed[b] = ~lv;
		end
		queue_read(o, b, lv, 16'($urandom));
	endfunction

	function automatic void queue_random_reads(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 82) begin
				queue_key_motion();
			end else begin
				queue_noise();
			end
		end
	endfunction

	// Returns once every queued item is taken and every expected event has come.
	task automatic wait_idle();
		while (reads_taken != reads_queued || key_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pin_mask(logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		pin_mask <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		mask_now = value;
		mask_writes++;
	endtask

	// Input driver: presents queued items, with random idle cycles between them.
	always @(posedge clk) begin : drive_reads
		bank_read_t nxt;
		logic       taken;
		if (arst_n) begin
			taken = in_valid && in_ready;
			if (taken) begin
				nxt = '{op: op_t'(op), bank: bank, levels: pin_levels, at_ms: now};
				predict_bank_read(nxt);
				reads_taken++;
			end
			if (!in_valid || taken) begin
				if (in_gap > 0 || bank_reads.size() == 0) begin
					if (in_gap > 0) begin
						in_gap--;
					end
					in_valid <= 1'b0;
				end else begin
					nxt = bank_reads.pop_front();
					op <= nxt.op;
					bank <= nxt.bank;
					pin_levels <= nxt.levels;
					now <= nxt.at_ms;
					in_valid <= 1'b1;
					in_gap = draw_gap(in_calm);
				end
			end
		end
	end

	// Output monitor: checks each event taken and stalls the output at random.
	always @(posedge clk) begin : watch_events
		logic taken;
		if (arst_n) begin
			taken = out_valid && out_ready;
			if (taken) begin
				check_key_event();
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				if (taken || $urandom_range(0, 7) == 0) begin
					out_stall = draw_gap(out_calm);
				end
				out_ready <= (out_stall == 0);
			end
		end
	end

	// Ends the run if no channel moves anything for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("No handshake for %0d cycles with %0d items and %0d events outstanding",
					STALL_LIMIT, reads_queued - reads_taken, key_events.size());
				$display("** velocity_key_matrix_scanner_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		// Reset falls just after time zero so the block sees a real falling edge.
		#1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		ms = 16'($urandom);

		// Directed part under the reset mask. A read that changes nothing.
		queue_read(OP_START, 3'd0, 8'hFF, 16'h0000);
		// A whole bank presses across the timer wrap: elapsed 254 gives 127.
		queue_read(OP_START, 3'd0, 8'h00, 16'hFFF0);
		queue_read(OP_FULL,  3'd0, 8'h00, 16'h00EE);
		queue_read(OP_FULL,  3'd0, 8'h00, 16'h0100);
		// Full-down contacts open: only history moves.
		queue_read(OP_FULL,  3'd0, 8'hFF, 16'h0110);
		// Start contacts open on eight keys that are down: eight key-offs.
		queue_read(OP_START, 3'd0, 8'hFF, 16'h0120);
		queue_read(OP_START, 3'd0, 8'hFF, 16'h0130);
		// Exactly 255 ms, then 256 ms across the wrap, on the top bank.
		queue_read(OP_START, 3'd7, 8'h7F, 16'h1000);
		queue_read(OP_FULL,  3'd7, 8'h7F, 16'h10FF);
		queue_read(OP_START, 3'd7, 8'h7E, 16'hFFFF);
		queue_read(OP_FULL,  3'd7, 8'h7E, 16'h00FF);
		// Zero and three milliseconds: velocities 0 and 1.
		queue_read(OP_START, 3'd3, 8'hDF, 16'h3000);
		queue_read(OP_FULL,  3'd3, 8'hDF, 16'h3000);
		queue_read(OP_START, 3'd3, 8'hDB, 16'h3010);
		queue_read(OP_FULL,  3'd3, 8'hDB, 16'h3013);
		// Full-down contact reopens and closes again on a key still down.
		queue_read(OP_FULL,  3'd3, 8'hFB, 16'h3020);
		queue_read(OP_FULL,  3'd3, 8'hDB, 16'h3030);
		// One key releases while another starts its press in the same read.
		queue_read(OP_START, 3'd3, 8'hBB, 16'h3040);
		// A partial press that never reaches the bottom sends nothing.
		queue_read(OP_START, 3'd4, 8'hFD, 16'h4000);
		queue_read(OP_START, 3'd4, 8'hFF, 16'h4010);
		// Full-down closes on keys whose stamps are still from reset.
		queue_read(OP_FULL,  3'd5, 8'h00, 16'h5000);
		wait_idle();

		// The two upper lines are masked off.
		write_pin_mask(8'h3F);
		queue_read(OP_START, 3'd2, 8'h00, 16'h6000);
		queue_read(OP_FULL,  3'd2, 8'h00, 16'h6050);
		queue_random_reads(100);
		wait_idle();

		write_pin_mask(8'($urandom));
		queue_random_reads(90);
		wait_idle();

		// Nothing gets through: keys held so far see their contacts drop.
		write_pin_mask(8'h00);
		queue_random_reads(15);
		wait_idle();

		write_pin_mask(8'hFF);
		queue_random_reads(140);
		wait_idle();

		$display("Run covered %0d bank reads and %0d key events (%0d key-on, %0d key-off).",
			reads_taken, events_checked, ons_seen, offs_seen);
		$display("The pin mask was written %0d times; %0d mismatches were found.",
			mask_writes, mismatches);
		if (mismatches == 0 && key_events.size() == 0) begin
			$display("** velocity_key_matrix_scanner_top: PASSED **");
		end else begin
			$display("** velocity_key_matrix_scanner_top: FAILED **");
		end
		$finish;
	end

endmodule
